/* hw/rtl/assert_macros.svh */
// Assertion macros for the top-level RTL of the gyro integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define GDAI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gyro integrator assertion failed");
// Checked at every rising edge, reset included.
`define GDAI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gyro integrator assertion failed");
`else
`define GDAI_ASSERT(label, clk, rst, prop)
`define GDAI_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hw/rtl/gdai_pkg.sv */
// Package with the types, widths and constants of the gyro delta-angle integrator.
package gdai_pkg;

  localparam int ANGLE_WIDTH     = 48;
  localparam int DELTA_WIDTH     = 32;
  localparam int COEF_WIDTH      = 16;
  localparam int COEF_FRAC       = 14;
  localparam int ROW_WIDTH       = 3 * COEF_WIDTH;
  localparam int STAMP_WIDTH     = 64;
  localparam int PERIOD_WIDTH    = 20;
  localparam int EARTH_WIDTH     = 16;
  localparam int EARTH_FRAC      = 16;
  localparam int MAX_INTERVAL_US = 1000000;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 48;

  localparam int PROD_WIDTH       = DELTA_WIDTH + COEF_WIDTH;
  localparam int ROT_SUM_WIDTH    = PROD_WIDTH + 2;
  localparam int ROT_OUT_WIDTH    = ROT_SUM_WIDTH - COEF_FRAC;
  localparam int EARTH_PROD_WIDTH = EARTH_WIDTH + PERIOD_WIDTH + 1;
  localparam int EARTH_OUT_WIDTH  = EARTH_PROD_WIDTH - EARTH_FRAC;

  localparam logic [ANGLE_WIDTH-1:0]  ROLL_RESET     = 48'd6746518852;
  localparam logic [ROW_WIDTH-1:0]    ROT_ROW0_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_WIDTH-1:0]    ROT_ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_WIDTH-1:0]    ROT_ROW2_RESET = 48'h4000_0000_0000;
  localparam logic [PERIOD_WIDTH-1:0] NOMINAL_RESET  = 20'd4000;

  typedef enum logic [2:0] {
    GAP_NORMAL   = 3'd0,
    GAP_FIRST    = 3'd1,
    GAP_DROPPED  = 3'd2,
    GAP_LONG     = 3'd3,
    GAP_BACKWARD = 3'd4
  } gap_status_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROT_ROW0       = 3'd0,
    CFG_ROT_ROW1       = 3'd1,
    CFG_ROT_ROW2       = 3'd2,
    CFG_EARTH_RATE     = 3'd3,
    CFG_NOMINAL_PERIOD = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [DELTA_WIDTH-1:0] delta_x;
    logic signed [DELTA_WIDTH-1:0] delta_y;
    logic signed [DELTA_WIDTH-1:0] delta_z;
    logic [STAMP_WIDTH-1:0]        sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic [STAMP_WIDTH-1:0]        stamp_out;
    logic [2:0]                    gap_status;
  } out_item_t;

endpackage

/* hw/rtl/gdai_rotate.sv */
// One row of the mounting matrix applied to the three delta angles, rounded to nearest.
module gdai_rotate import gdai_pkg::*; (
  input  logic [ROW_WIDTH-1:0]            row,
  input  logic signed [DELTA_WIDTH-1:0]   dx,
  input  logic signed [DELTA_WIDTH-1:0]   dy,
  input  logic signed [DELTA_WIDTH-1:0]   dz,
  output logic signed [ROT_OUT_WIDTH-1:0] delta
);

  logic signed [COEF_WIDTH-1:0]    cx, cy, cz;
  logic signed [PROD_WIDTH-1:0]    px, py, pz;
  logic signed [ROT_SUM_WIDTH-1:0] sum;
  logic [ROT_SUM_WIDTH-1:0]        biased;

  assign cx = $signed(row[COEF_WIDTH-1:0]);
  assign cy = $signed(row[2*COEF_WIDTH-1:COEF_WIDTH]);
  assign cz = $signed(row[3*COEF_WIDTH-1:2*COEF_WIDTH]);

  assign px = cx * dx;
  assign py = cy * dy;
  assign pz = cz * dz;

  assign sum = $signed({{(ROT_SUM_WIDTH-PROD_WIDTH){px[PROD_WIDTH-1]}}, px})
             + $signed({{(ROT_SUM_WIDTH-PROD_WIDTH){py[PROD_WIDTH-1]}}, py})
             + $signed({{(ROT_SUM_WIDTH-PROD_WIDTH){pz[PROD_WIDTH-1]}}, pz});

  // Adding half an LSB and dropping the fraction bits rounds halves upwards.
  assign biased = sum + ROT_SUM_WIDTH'(2 ** (COEF_FRAC - 1));
  assign delta  = $signed(biased[ROT_SUM_WIDTH-1:COEF_FRAC]);

endmodule

/* hw/rtl/gdai_interval.sv */
// Sample interval, gap status and the earth-rate correction for roll.
module gdai_interval import gdai_pkg::*; (
  input  logic [STAMP_WIDTH-1:0]            now,
  input  logic [STAMP_WIDTH-1:0]            prev_time,
  input  logic                              seen,
  input  logic [PERIOD_WIDTH-1:0]           nominal,
  input  logic signed [EARTH_WIDTH-1:0]     earth,
  output gap_status_t                       status,
  output logic signed [EARTH_OUT_WIDTH-1:0] earth_term
);

  logic [STAMP_WIDTH-1:0]          diff;
  logic [PERIOD_WIDTH-1:0]         interval;
  logic [PERIOD_WIDTH+2:0]         twice_diff;
  logic [PERIOD_WIDTH+2:0]         five_nominal;
  logic                            dropped;
  logic signed [EARTH_PROD_WIDTH-1:0] prod;
  logic [EARTH_PROD_WIDTH-1:0]     biased;

  assign diff         = now - prev_time;
  assign twice_diff   = {2'b00, diff[PERIOD_WIDTH-1:0], 1'b0};
  assign five_nominal = {3'b000, nominal} + {1'b0, nominal, 2'b00};
  assign dropped      = twice_diff > five_nominal;

  always_comb begin
    interval = nominal;
    status   = GAP_NORMAL;
    if (!seen) begin
      status = GAP_FIRST;
    end else if (now < prev_time) begin
      status = GAP_BACKWARD;
    end else if (diff < STAMP_WIDTH'(MAX_INTERVAL_US)) begin
      interval = diff[PERIOD_WIDTH-1:0];
      status   = dropped ? GAP_DROPPED : GAP_NORMAL;
    end else begin
      status = GAP_LONG;
    end
  end

  assign prod       = earth * $signed({1'b0, interval});
  assign biased     = prod + EARTH_PROD_WIDTH'(2 ** (EARTH_FRAC - 1));
  assign earth_term = $signed(biased[EARTH_PROD_WIDTH-1:EARTH_FRAC]);

endmodule

/* hw/rtl/gyro_delta_angle_integrator.sv */
// Top level of the gyro delta-angle integrator: registers, accumulators and handshakes.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_data   (in_item_t: three deltas, stamp)
//   out      out_valid / out_ready  out_data  (out_item_t: three angles, stamp, status)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (write only)
//
// A sample is captured in an input register and its result is then written to the output
// register; while the output is not stalled, one sample can be taken every cycle. The
// matrix multiply and accumulate for one sample fit between the input and output
// registers. A stalled output holds the pipeline; the input register still takes a
// transfer while it is empty, or in the cycle that its sample moves on to the output.
// Reset is synchronous; the angles return to zero, roll to pi/2.
`include "assert_macros.svh"

module gyro_delta_angle_integrator import gdai_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic [ROW_WIDTH-1:0]          rot_row0, rot_row1, rot_row2;
  logic signed [EARTH_WIDTH-1:0] earth_rate;
  logic [PERIOD_WIDTH-1:0]       nominal_period_us;

  logic                          s1_valid;
  in_item_t                      s1_data;

  logic [ANGLE_WIDTH-1:0]        yaw_acc, pitch_acc, roll_acc;
  logic [ANGLE_WIDTH-1:0]        yaw_next, pitch_next, roll_next;
  logic [STAMP_WIDTH-1:0]        prev_time;
  logic                          seen_sample;

  logic signed [ROT_OUT_WIDTH-1:0]   d_yaw, d_pitch, d_roll;
  logic signed [EARTH_OUT_WIDTH-1:0] earth_term;
  gap_status_t                       status;
  logic                              adv;

  gdai_rotate u_rot_yaw (
    .row(rot_row0), .dx(s1_data.delta_x), .dy(s1_data.delta_y), .dz(s1_data.delta_z),
    .delta(d_yaw)
  );

  gdai_rotate u_rot_pitch (
    .row(rot_row1), .dx(s1_data.delta_x), .dy(s1_data.delta_y), .dz(s1_data.delta_z),
    .delta(d_pitch)
  );

  gdai_rotate u_rot_roll (
    .row(rot_row2), .dx(s1_data.delta_x), .dy(s1_data.delta_y), .dz(s1_data.delta_z),
    .delta(d_roll)
  );

  gdai_interval u_interval (
    .now(s1_data.sample_time),
    .prev_time(prev_time),
    .seen(seen_sample),
    .nominal(nominal_period_us),
    .earth(earth_rate),
    .status(status),
    .earth_term(earth_term)
  );

  // The captured sample moves on when the output register is free or being emptied.
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || adv;
  assign cfg_ready = 1'b1;

  assign yaw_next   = yaw_acc
                    + {{(ANGLE_WIDTH-ROT_OUT_WIDTH){d_yaw[ROT_OUT_WIDTH-1]}}, d_yaw};
  assign pitch_next = pitch_acc
                    + {{(ANGLE_WIDTH-ROT_OUT_WIDTH){d_pitch[ROT_OUT_WIDTH-1]}}, d_pitch};
  assign roll_next  = roll_acc
                    + {{(ANGLE_WIDTH-ROT_OUT_WIDTH){d_roll[ROT_OUT_WIDTH-1]}}, d_roll}
                    + {{(ANGLE_WIDTH-EARTH_OUT_WIDTH){earth_term[EARTH_OUT_WIDTH-1]}},
                       earth_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0          <= ROT_ROW0_RESET;
      rot_row1          <= ROT_ROW1_RESET;
      rot_row2          <= ROT_ROW2_RESET;
      earth_rate        <= '0;
      nominal_period_us <= NOMINAL_RESET;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      yaw_acc           <= '0;
      pitch_acc         <= '0;
      roll_acc          <= ROLL_RESET;
      prev_time         <= '0;
      seen_sample       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROT_ROW0:       rot_row0          <= cfg_data[ROW_WIDTH-1:0];
          CFG_ROT_ROW1:       rot_row1          <= cfg_data[ROW_WIDTH-1:0];
          CFG_ROT_ROW2:       rot_row2          <= cfg_data[ROW_WIDTH-1:0];
          CFG_EARTH_RATE:     earth_rate        <= $signed(cfg_data[EARTH_WIDTH-1:0]);
          CFG_NOMINAL_PERIOD: nominal_period_us <= cfg_data[PERIOD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid   <= 1'b1;
        yaw_acc     <= yaw_next;
        pitch_acc   <= pitch_next;
        roll_acc    <= roll_next;
        prev_time   <= s1_data.sample_time;
        seen_sample <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (adv) begin
      out_data.yaw_angle   <= $signed(yaw_next);
      out_data.pitch_angle <= $signed(pitch_next);
      out_data.roll_angle  <= $signed(roll_next);
      out_data.stamp_out   <= s1_data.sample_time;
      out_data.gap_status  <= status;
    end
  end

  `GDAI_ASSERT_ALWAYS(a_ready_when_empty, clk, !s1_valid |-> in_ready)
  `GDAI_ASSERT(a_first_status, clk, rst,
               adv && !seen_sample |=> out_data.gap_status == GAP_FIRST)
  `GDAI_ASSERT(a_prev_tracks_out, clk, rst, adv |=> prev_time == out_data.stamp_out)
  `GDAI_ASSERT(a_seen_sticks, clk, rst, seen_sample |=> seen_sample)
  `GDAI_ASSERT(a_status_range, clk, rst,
               out_valid |-> out_data.gap_status <= GAP_BACKWARD)

endmodule
